@@ hdl/assert_macros.svh @@
// Assertion macros shared by the converter modules.
// Standalone header; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, disabled while in reset.
`define RHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the rising clock edge, also during reset.
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rstn, prop, msg)
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/rhc_pkg.sv @@
// Shared types, constants and the division step for the RGB to HSV converter.
// No dependencies; every other module imports this package.
package rhc_pkg;

    localparam int QUEUE_DEPTH = 4;

    // hue quotient is at most 3840, saturation quotient at most 255
    localparam int HUE_QW = 12;
    localparam int SAT_QW = 8;

    localparam logic [14:0] SECTOR_UNITS = 15'd3840;
    localparam logic [14:0] GREEN_OFFSET = 15'd7680;
    localparam logic [14:0] BLUE_OFFSET  = 15'd15360;
    localparam logic [14:0] FULL_CIRCLE  = 15'd23040;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  value;
    } hsv_t;

    typedef enum logic [1:0] {
        SEC_GREY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Classified pixel handed from the front end to the divider pipeline
    typedef struct packed {
        sector_t     sector;
        logic        neg;
        logic [19:0] hnum;
        logic [7:0]  chroma;
        logic [15:0] snum;
        logic [7:0]  vmax;
    } work_t;

    // One restoring division step: returns {quotient bit, new remainder}.
    // The remainder stays below the divisor, so 8 bits suffice.
    function automatic logic [8:0] div_step(input logic [7:0] rem,
                                            input logic       nbit,
                                            input logic [7:0] dvsr);
        logic [8:0] trial;
        logic [8:0] diff;
        begin
            trial = {rem, nbit};
            diff  = trial - {1'b0, dvsr};
            if (trial >= {1'b0, dvsr})
                div_step = {1'b1, diff[7:0]};
            else
                div_step = {1'b0, trial[7:0]};
        end
    endfunction

endpackage

@@ hdl/rhc_front.sv @@
// Front end: registers an incoming pixel, finds max, min, chroma and hue sector.
// Depends on rhc_pkg.
module rhc_front
    import rhc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   push,
    input  logic   full,
    output work_t  item
);

    logic  vld_reg;
    work_t item_reg;
    work_t item_next;

    always_comb
    begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] vmax;
        logic [7:0] vmin;
        logic [7:0] chroma;
        logic [8:0] diff;
        logic [7:0] mag;
        r = pixel.red;
        g = pixel.green;
        b = pixel.blue;
        vmax = r;
        vmin = r;
        if (g > vmax) vmax = g;
        if (b > vmax) vmax = b;
        if (g < vmin) vmin = g;
        if (b < vmin) vmin = b;
        chroma = vmax - vmin;
        // ties resolve toward red, then green
        if (chroma == 8'd0)
        begin
            item_next.sector = SEC_GREY;
            diff = 9'd0;
        end
        else if (vmax == r)
        begin
            item_next.sector = SEC_RED;
            diff = {1'b0, g} - {1'b0, b};
        end
        else if (vmax == g)
        begin
            item_next.sector = SEC_GREEN;
            diff = {1'b0, b} - {1'b0, r};
        end
        else
        begin
            item_next.sector = SEC_BLUE;
            diff = {1'b0, r} - {1'b0, g};
        end
        mag = diff[8] ? 8'(-diff) : diff[7:0];
        item_next.neg    = diff[8];
        // 3840 * |diff| as 4096x - 256x
        item_next.hnum   = {mag, 12'd0} - {4'd0, mag, 8'd0};
        item_next.chroma = chroma;
        // 255 * chroma as 256x - x
        item_next.snum   = {chroma, 8'd0} - {8'd0, chroma};
        item_next.vmax   = vmax;
    end

    assign pixel_stall = vld_reg && full;
    assign push        = vld_reg && !full;
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!pixel_stall)
            vld_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!pixel_stall && pixel_valid)
            item_reg <= item_next;
    end

endmodule

@@ hdl/rhc_queue.sv @@
// Short queue between the classifying front end and the divider pipeline.
// Depends on rhc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rhc_queue
    import rhc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t wr_item,
    output logic  full,
    input  logic  pop,
    output logic  nonempty,
    output work_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    work_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    `RHC_ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CW'(DEPTH), "queue count overflow")
    `RHC_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> nonempty, "pop from empty queue")
    `RHC_ASSERT(a_no_push_full, clk, rst_n, push |-> !full, "push into full queue")
    `RHC_ASSERT(a_count_up, clk, rst_n, (push && !pop) |=> count_reg == $past(count_reg) + CW'(1), "queue count did not advance")

endmodule

@@ hdl/rhc_back.sv @@
// Back end: pipelined restoring dividers for hue and saturation, then the
// sector offset and wrap. Depends on rhc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rhc_back
    import rhc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  work_t head,
    output logic  pop,
    output logic  hsv_valid,
    input  logic  hsv_stall,
    output hsv_t  hsv
);

    localparam int NSTG = HUE_QW;

    logic                vld_reg    [1:NSTG];
    sector_t             sec_reg    [1:NSTG];
    logic                neg_reg    [1:NSTG];
    logic [7:0]          chroma_reg [1:NSTG];
    logic [7:0]          vmax_reg   [1:NSTG];
    logic [7:0]          hrem_reg   [1:NSTG];
    logic [HUE_QW-1:0]   hlo_reg    [1:NSTG];
    logic [HUE_QW-1:0]   hq_reg     [1:NSTG];
    logic [7:0]          srem_reg   [1:NSTG];
    logic [SAT_QW-1:0]   slo_reg    [1:NSTG];
    logic [SAT_QW-1:0]   sq_reg     [1:NSTG];

    // stage inputs: stage 1 takes the queue head, later ones the stage before
    logic                in_vld    [1:NSTG];
    sector_t             in_sec    [1:NSTG];
    logic                in_neg    [1:NSTG];
    logic [7:0]          in_chroma [1:NSTG];
    logic [7:0]          in_vmax   [1:NSTG];
    logic [7:0]          in_hrem   [1:NSTG];
    logic [HUE_QW-1:0]   in_hlo    [1:NSTG];
    logic [HUE_QW-1:0]   in_hq     [1:NSTG];
    logic [7:0]          in_srem   [1:NSTG];
    logic [SAT_QW-1:0]   in_slo    [1:NSTG];
    logic [SAT_QW-1:0]   in_sq     [1:NSTG];

    logic advance;
    logic out_vld_reg;
    hsv_t out_reg;
    hsv_t out_next;

    // the whole pipe moves together unless a finished result is held
    assign advance   = !out_vld_reg || !hsv_stall;
    assign pop       = advance && head_valid;
    assign hsv_valid = out_vld_reg;
    assign hsv       = out_reg;

    always_comb
    begin
        in_vld[1]    = head_valid;
        in_sec[1]    = head.sector;
        in_neg[1]    = head.neg;
        in_chroma[1] = head.chroma;
        in_vmax[1]   = head.vmax;
        in_hrem[1]   = head.hnum[19:HUE_QW];
        in_hlo[1]    = head.hnum[HUE_QW-1:0];
        in_hq[1]     = '0;
        in_srem[1]   = head.snum[15:SAT_QW];
        in_slo[1]    = head.snum[SAT_QW-1:0];
        in_sq[1]     = '0;
        for (int s = 2; s <= NSTG; s++)
        begin
            in_vld[s]    = vld_reg[s-1];
            in_sec[s]    = sec_reg[s-1];
            in_neg[s]    = neg_reg[s-1];
            in_chroma[s] = chroma_reg[s-1];
            in_vmax[s]   = vmax_reg[s-1];
            in_hrem[s]   = hrem_reg[s-1];
            in_hlo[s]    = hlo_reg[s-1];
            in_hq[s]     = hq_reg[s-1];
            in_srem[s]   = srem_reg[s-1];
            in_slo[s]    = slo_reg[s-1];
            in_sq[s]     = sq_reg[s-1];
        end
    end

    for (genvar s = 1; s <= NSTG; s++)
    begin : g_stage
        logic [8:0] hstep;
        logic [8:0] sstep;

        assign hstep = div_step(in_hrem[s], in_hlo[s][HUE_QW-1], in_chroma[s]);
        assign sstep = div_step(in_srem[s], in_slo[s][SAT_QW-1], in_vmax[s]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (advance)
                vld_reg[s] <= in_vld[s];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sec_reg[s]    <= in_sec[s];
                neg_reg[s]    <= in_neg[s];
                chroma_reg[s] <= in_chroma[s];
                vmax_reg[s]   <= in_vmax[s];
                hrem_reg[s]   <= hstep[7:0];
                hlo_reg[s]    <= {in_hlo[s][HUE_QW-2:0], 1'b0};
                hq_reg[s]     <= {in_hq[s][HUE_QW-2:0], hstep[8]};
                // saturation finishes early; hold it for the remaining stages
                if (s <= SAT_QW)
                begin
                    srem_reg[s] <= sstep[7:0];
                    slo_reg[s]  <= {in_slo[s][SAT_QW-2:0], 1'b0};
                    sq_reg[s]   <= {in_sq[s][SAT_QW-2:0], sstep[8]};
                end
                else
                begin
                    srem_reg[s] <= in_srem[s];
                    slo_reg[s]  <= in_slo[s];
                    sq_reg[s]   <= in_sq[s];
                end
            end
        end
    end

    always_comb
    begin
        logic [14:0] frac;
        // a negative fraction rounds down: bump the magnitude on a remainder
        frac = {3'd0, hq_reg[NSTG]};
        if (neg_reg[NSTG] && (hrem_reg[NSTG] != 8'd0))
            frac = frac + 15'd1;
        unique case (sec_reg[NSTG])
            SEC_GREY:  out_next.hue = 15'd0;
            SEC_RED:   out_next.hue = (neg_reg[NSTG] && frac != 15'd0) ?
                                      FULL_CIRCLE - frac : frac;
            SEC_GREEN: out_next.hue = neg_reg[NSTG] ? GREEN_OFFSET - frac
                                                    : GREEN_OFFSET + frac;
            SEC_BLUE:  out_next.hue = neg_reg[NSTG] ? BLUE_OFFSET - frac
                                                    : BLUE_OFFSET + frac;
            default:   out_next.hue = 15'd0;
        endcase
        out_next.saturation = (vmax_reg[NSTG] == 8'd0) ? 8'd0 : sq_reg[NSTG];
        out_next.value      = vmax_reg[NSTG];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (advance && vld_reg[NSTG])
            out_reg <= out_next;
    end

    `RHC_ASSERT(a_hue_range, clk, rst_n, hsv_valid |-> hsv.hue < FULL_CIRCLE, "hue out of range")
    `RHC_ASSERT(a_black_sat, clk, rst_n, (hsv_valid && hsv.value == 8'd0) |-> hsv.saturation == 8'd0, "black pixel with saturation")
    `RHC_ASSERT(a_pipe_hold, clk, rst_n, !advance |=> vld_reg[1] == $past(vld_reg[1]), "pipeline moved while held")
    `RHC_ASSERT(a_pop_advance, clk, rst_n, pop |-> advance, "queue popped while pipeline held")

endmodule

@@ hdl/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: one 8-bit RGB pixel in, hue, saturation and value out.
// Front end, decoupling queue and divider pipeline; all from rhc_pkg.
//
// Input channel: pixel_valid / pixel_stall with payload pixel (red, green,
// blue). A pixel transaction completes on a rising edge with pixel_valid
// high and pixel_stall low.
// Output channel: hsv_valid / hsv_stall with payload hsv (hue in 1/64 degree,
// saturation, value). One result per pixel, in input order.
// Throughput: one pixel per clock while the output is not stalled.
// Registers from the input transaction to hsv_valid: the front
// register takes the pixel on the transaction edge, then one queue slot,
// twelve restoring-division stages (one quotient bit of the hue each;
// saturation needs eight of them) and the output register follow.
// When the receiver stalls, the result holds and the divider pipeline
// freezes; the queue keeps taking pixels until it fills, then pixel_stall
// rises. Reset empties the pipeline, the queue and the output; no clearing
// pass is needed, so pixels are taken from the first cycle after reset.
module rgb_to_hsv_converter
    import rhc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   hsv_valid,
    input  logic   hsv_stall,
    output hsv_t   hsv
);

    logic  push;
    logic  full;
    logic  pop;
    logic  nonempty;
    work_t front_item;
    work_t head;

    rhc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .push        (push),
        .full        (full),
        .item        (front_item)
    );

    rhc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (front_item),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .head     (head)
    );

    rhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (nonempty),
        .head       (head),
        .pop        (pop),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hsv        (hsv)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for rgb_to_hsv_converter: directed corner pixels, then random
// pixels with random idle on both channels, checked against an in-bench HSV predictor.
// Depends on rhc_pkg (pixel_t, hsv_t) and the converter RTL.
module testbench;
    import rhc_pkg::*;

    localparam int RANDOM_PIXELS = 1230;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 30;

    // Expected HSV results in input order, with the arithmetic that produces them
    class hsv_ledger;
        localparam int HUE_PER_SECTOR = 3840;
        localparam int HUE_CIRCLE     = 23040;

        hsv_t pending_hsv[$];
        int   error_count;

        function new();
            error_count = 0;
        endfunction

        function hsv_t expected_hsv(pixel_t px);
            int   r;
            int   g;
            int   b;
            int   vmax;
            int   vmin;
            int   chroma;
            int   diff;
            int   num;
            int   hue;
            int   sat;
            hsv_t res;
            r    = px.red;
            g    = px.green;
            b    = px.blue;
            vmax = r;
            vmin = r;
            if (g > vmax) vmax = g;
            if (b > vmax) vmax = b;
            if (g < vmin) vmin = g;
            if (b < vmin) vmin = b;
            chroma = vmax - vmin;
            if (chroma == 0)
                hue = 0;
            else
            begin
                // ties resolve to red, then green
                if (vmax == r)
                begin
                    diff = g - b;
                    hue  = 0;
                end
                else if (vmax == g)
                begin
                    diff = b - r;
                    hue  = 2 * HUE_PER_SECTOR;
                end
                else
                begin
                    diff = r - g;
                    hue  = 4 * HUE_PER_SECTOR;
                end
                num = HUE_PER_SECTOR * diff;
                // floor toward minus infinity
                if (num >= 0)
                    hue = hue + num / chroma;
                else
                    hue = hue - (-num + chroma - 1) / chroma;
            end
            if (hue < 0)
                hue = hue + HUE_CIRCLE;
            if (vmax == 0)
                sat = 0;
            else
                sat = (255 * chroma) / vmax;
            res.hue        = hue[14:0];
            res.saturation = sat[7:0];
            res.value      = vmax[7:0];
            return res;
        endfunction

        function void note_pixel(pixel_t px);
            pending_hsv.push_back(expected_hsv(px));
        endfunction

        function void check_hsv(hsv_t got);
            hsv_t want;
            if (pending_hsv.size() == 0)
            begin
                $error("unexpected hsv transaction: hue %0d saturation %0d value %0d",
                       got.hue, got.saturation, got.value);
                error_count++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (got.hue !== want.hue)
                begin
                    $error("hue: expected %0d, actual %0d", want.hue, got.hue);
                    error_count++;
                end
                if (got.saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, actual %0d",
                           want.saturation, got.saturation);
                    error_count++;
                end
                if (got.value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, got.value);
                    error_count++;
                end
            end
        endfunction

        function int pending();
            return pending_hsv.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   pixel_valid;
    logic   pixel_stall;
    pixel_t pixel;
    logic   hsv_valid;
    logic   hsv_stall;
    hsv_t   hsv;

    hsv_ledger ledger = new();
    bit        pixel_idle_on = 1'b1;
    bit        hsv_idle_on = 1'b1;

    rgb_to_hsv_converter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel      (pixel),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hsv        (hsv)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Present one pixel after a random gap and hold it until the transaction completes.
    // Valid stays high into the next pixel when that one draws no gap.
    task automatic send_pixel(input pixel_t px);
        int gap;
        if ($urandom_range(0, 39) == 0)
            pixel_idle_on = !pixel_idle_on;
        gap = pixel_idle_on ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel       <= px;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        ledger.note_pixel(px);
    endtask

    initial
    begin
        pixel_t px;
        int     pick;
        int     n;
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // black, white, grey
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd128, 8'd128});
        send_pixel({8'd1, 8'd1, 8'd1});
        // primaries and secondaries
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd255});
        send_pixel({8'd255, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd255});
        send_pixel({8'd255, 8'd0, 8'd255});
        // red largest with blue above green wraps the hue
        send_pixel({8'd255, 8'd0, 8'd1});
        send_pixel({8'd255, 8'd0, 8'd254});
        send_pixel({8'd2, 8'd0, 8'd1});
        // smallest nonzero chroma and near ties
        send_pixel({8'd1, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd1, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd1});
        send_pixel({8'd255, 8'd254, 8'd0});
        send_pixel({8'd0, 8'd1, 8'd255});
        send_pixel({8'd254, 8'd255, 8'd255});
        send_pixel({8'd200, 8'd100, 8'd150});
        send_pixel({8'd17, 8'd240, 8'd3});
        send_pixel({8'd90, 8'd31, 8'd252});

        for (n = 0; n < RANDOM_PIXELS; n++)
        begin
            pick = $urandom_range(0, 9);
            px   = 24'($urandom);
            if (pick == 0)
            begin
                px.green = px.red;
                px.blue  = px.red;
            end
            else if (pick <= 2)
            begin
                case ($urandom_range(0, 2))
                    0:       px.green = px.red;
                    1:       px.blue = px.red;
                    default: px.blue = px.green;
                endcase
            end
            else if (pick == 3)
            begin
                px.red   = 8'($urandom_range(0, 3));
                px.green = 8'($urandom_range(0, 3));
                px.blue  = 8'($urandom_range(0, 3));
            end
            else if (pick == 4)
            begin
                // one component at full scale, another near it
                px.red   = 8'd255;
                px.green = 8'($urandom_range(250, 255));
            end
            send_pixel(px);
        end

        @(negedge clk);
        pixel_valid <= 1'b0;

        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.error_count == 0 && ledger.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: raise hsv_stall for a random gap, then take one transaction.
    initial
    begin
        int gap;
        hsv_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                hsv_idle_on = !hsv_idle_on;
            gap = hsv_idle_on ? $urandom_range(0, 10) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                hsv_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            hsv_stall <= 1'b0;
            @(posedge clk);
            while (!hsv_valid)
                @(posedge clk);
            ledger.check_hsv(hsv);
        end
    end

    // Abort when no transaction completes on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (hsv_valid && !hsv_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_queue.sv
hdl/rhc_back.sv
hdl/rgb_to_hsv_converter.sv
tb/testbench.sv
